// ----- rtl/tcc_pkg.sv -----
// Shared widths, constants and item type of the triangle circumcentre block.
package tcc_pkg;

  localparam int IW      = 32;            // input coordinate width
  localparam int DIFW    = IW + 1;        // differences and sums of two coordinates
  localparam int PRW     = 2 * DIFW;      // product of two differences
  localparam int DETW    = PRW + 1;       // determinant and bisector terms
  localparam int SPLW    = DIFW + 1;      // low slice of a determinant-wide term
  localparam int NUMW    = DETW + DIFW + 1; // Cramer numerators
  localparam int DENW    = DETW + 1;      // twice the determinant magnitude
  localparam int QW      = 48;            // result width
  localparam int CMPW    = DENW + QW;     // width of the range compare
  localparam int QDEPTH  = 4;             // front-to-back queue depth
  localparam int QAW     = $clog2(QDEPTH);
  localparam int FR_LAT  = 6;             // front pipeline stages
  localparam int DIV_LAT = QW + 3;        // divider pipeline stages

  typedef struct packed {
    logic signed [NUMW-1:0] nx;
    logic signed [NUMW-1:0] ny;
    logic signed [DETW-1:0] d;
  } tcc_item_t;

endpackage

// ----- rtl/triangle_circumcenter.sv -----
// Top level of the triangle circumcentre block.
// Usage:
//   Input channel (in_valid/in_ready) takes one triangle per item: three points
//   ax/ay, bx/by_coord, cx/cy in signed Q16.16.
//   Output channel (out_valid/out_ready) gives one item per triangle:
//   center_x/center_y in signed Q32.16, truncated toward zero and clamped to
//   48 bits, valid_res low (and all else zero) for collinear points, and
//   saturated high when either centre was clamped.
// Throughput: one item per cycle, sustained while out_ready stays high.
// Path: the input accept edge loads the first of 6 front stages
//   (differences, 33x33 products, determinant, split products, recombine,
//   numerators); the item then passes through the queue and 51 divider
//   stages (magnitudes, range check, one quotient bit per stage for 48
//   bits, clamp).
// Stall: when out_ready is low with out_valid high the back pipeline holds; the 4-item queue then
//   fills from the front, and in_ready drops once the queue is full and the
//   last front stage holds an item.
// Reset: rst, synchronous, empties both pipelines and the queue; no item is
//   held after reset. The block keeps no state between items.
module triangle_circumcenter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by_coord,
  input  logic signed [31:0] cx,
  input  logic signed [31:0] cy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] center_x,
  output logic signed [47:0] center_y,
  output logic               valid_res,
  output logic               saturated
);
  import tcc_pkg::*;

  // front to queue
  tcc_item_t f_item, q_item;
  logic f_valid, f_ready, q_valid, q_ready;

  tcc_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .ax, .ay, .bx, .by_coord, .cx, .cy,
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  // decouple the two halves so each can stall on its own
  tcc_queue u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
  );

  tcc_back u_back (
    .clk, .rst,
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid, .out_ready,
    .center_x, .center_y, .valid_res, .saturated
  );

endmodule

// ----- rtl/tcc_front.sv -----
// Front pipeline: differences, determinant and the two Cramer numerators.
module tcc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          ax,
  input  logic signed [31:0]          ay,
  input  logic signed [31:0]          bx,
  input  logic signed [31:0]          by_coord,
  input  logic signed [31:0]          cx,
  input  logic signed [31:0]          cy,
  output logic                        item_valid,
  input  logic                        item_ready,
  output tcc_pkg::tcc_item_t          item
);
  import tcc_pkg::*;

  logic [FR_LAT-1:0] v;
  logic en;

  logic signed [DIFW-1:0] dx0, dy0, dx1, dy1, sx0, sy0, sx1, sy1;
  logic signed [DIFW-1:0] s2_dx0, s2_dy0, s2_dx1, s2_dy1;
  logic signed [DIFW-1:0] s3_dx0, s3_dy0, s3_dx1, s3_dy1;
  logic signed [PRW-1:0]  m_a, m_b, m_c, m_d, m_e, m_f;
  logic signed [DETW-1:0] d3, p3, q3, d4, d5, d6;
  logic signed [PRW-1:0]  hi4 [4];
  logic signed [DENW-1:0] lo4 [4];
  logic signed [NUMW-1:0] pr5 [4];
  logic signed [NUMW-1:0] nx6, ny6;
  logic signed [DIFW-1:0] ph, qh;
  logic signed [SPLW-1:0] pl, ql;

  assign en         = !v[FR_LAT-1] || item_ready;
  assign in_ready   = en;
  assign item_valid = v[FR_LAT-1];
  assign item.nx    = nx6;
  assign item.ny    = ny6;
  assign item.d     = d6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[FR_LAT-2:0], in_valid};
    end
  end

  // the bisector terms stay within +-2^63, so their top bits are all sign
  assign ph = p3[DETW-2:SPLW-1];
  assign qh = q3[DETW-2:SPLW-1];
  assign pl = {1'b0, p3[SPLW-2:0]};
  assign ql = {1'b0, q3[SPLW-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      dx0 <= DIFW'(ax) - DIFW'(cx);
      dy0 <= DIFW'(ay) - DIFW'(cy);
      dx1 <= DIFW'(bx) - DIFW'(cx);
      dy1 <= DIFW'(by_coord) - DIFW'(cy);
      sx0 <= DIFW'(ax) + DIFW'(cx);
      sy0 <= DIFW'(ay) + DIFW'(cy);
      sx1 <= DIFW'(bx) + DIFW'(cx);
      sy1 <= DIFW'(by_coord) + DIFW'(cy);

      m_a <= dx0 * dy1;
      m_b <= dx1 * dy0;
      m_c <= dx0 * sx0;
      m_d <= dy0 * sy0;
      m_e <= dx1 * sx1;
      m_f <= dy1 * sy1;
      s2_dx0 <= dx0; s2_dy0 <= dy0; s2_dx1 <= dx1; s2_dy1 <= dy1;

      d3 <= DETW'(m_a) - DETW'(m_b);
      p3 <= DETW'(m_c) + DETW'(m_d);
      q3 <= DETW'(m_e) + DETW'(m_f);
      s3_dx0 <= s2_dx0; s3_dy0 <= s2_dy0; s3_dx1 <= s2_dx1; s3_dy1 <= s2_dy1;

      // split the wide terms so that each multiply stays near 33 by 33
      hi4[0] <= ph * s3_dy1;
      lo4[0] <= pl * s3_dy1;
      hi4[1] <= qh * s3_dy0;
      lo4[1] <= ql * s3_dy0;
      hi4[2] <= qh * s3_dx0;
      lo4[2] <= ql * s3_dx0;
      hi4[3] <= ph * s3_dx1;
      lo4[3] <= pl * s3_dx1;
      d4 <= d3;

      for (int k = 0; k < 4; k++) begin
        pr5[k] <= (NUMW'(hi4[k]) <<< (SPLW - 1)) + NUMW'(lo4[k]);
      end
      d5 <= d4;

      nx6 <= pr5[0] - pr5[1];
      ny6 <= pr5[2] - pr5[3];
      d6  <= d5;
    end
  end

endmodule

// ----- rtl/tcc_queue.sv -----
// Short FIFO between the front and back pipelines.
module tcc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  tcc_pkg::tcc_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output tcc_pkg::tcc_item_t pop_item
);
  import tcc_pkg::*;

  tcc_item_t    slots [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic push, pop;

  assign push_ready = count != QDEPTH[QAW:0];
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ----- rtl/tcc_div.sv -----
// Pipelined signed divide of a numerator by twice a determinant, saturated to 48 bits.
module tcc_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tcc_pkg::NUMW-1:0]   num,
  input  logic signed [tcc_pkg::DETW-1:0]   det,
  output logic signed [tcc_pkg::QW-1:0]     quo,
  output logic                              sat
);
  import tcc_pkg::*;

  localparam logic [QW-1:0] MAXV = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] MINV = {1'b1, {(QW-1){1'b0}}};

  logic [NUMW-1:0] n0;
  logic [DENW-1:0] dm0;
  logic            neg0;

  logic [NUMW-1:0] rp   [QW+1];
  logic [QW-1:0]   qp   [QW+1];
  logic [DENW-1:0] dmp  [QW+1];
  logic            negp [QW+1];
  logic            ovfp [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n0   <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
      dm0  <= det[DETW-1] ? {DENW'(-det)} << 1 : {DENW'(det)} << 1;
      neg0 <= num[NUMW-1] ^ det[DETW-1];

      // a quotient of 2^48 or more saturates whatever its sign
      ovfp[0] <= CMPW'(n0) >= {dm0, {QW{1'b0}}};
      rp[0]   <= n0;
      qp[0]   <= '0;
      dmp[0]  <= dm0;
      negp[0] <= neg0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [CMPW-1:0] trial;
    logic            take;
    assign trial = CMPW'(dmp[j]) << K;
    assign take  = CMPW'(rp[j]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rp[j+1]   <= take ? NUMW'(CMPW'(rp[j]) - trial) : rp[j];
        qp[j+1]   <= qp[j] | (QW'(take) << K);
        dmp[j+1]  <= dmp[j];
        negp[j+1] <= negp[j];
        ovfp[j+1] <= ovfp[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (ovfp[QW]) begin
        quo <= negp[QW] ? MINV : MAXV;
        sat <= 1'b1;
      end else if (negp[QW]) begin
        quo <= (qp[QW] > MINV) ? MINV : -qp[QW];
        sat <= qp[QW] > MINV;
      end else begin
        quo <= (qp[QW] > MAXV) ? MAXV : qp[QW];
        sat <= qp[QW] > MAXV;
      end
    end
  end

endmodule

// ----- rtl/tcc_back.sv -----
// Back pipeline: two dividers, collinear flag and the result stage.
module tcc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  tcc_pkg::tcc_item_t        item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [47:0]        center_x,
  output logic signed [47:0]        center_y,
  output logic                      valid_res,
  output logic                      saturated
);
  import tcc_pkg::*;

  logic [DIV_LAT-1:0] v, zero;
  logic en;
  logic signed [QW-1:0] qx, qy;
  logic sx, sy;

  assign en         = !v[DIV_LAT-1] || out_ready;
  assign item_ready = en;
  assign out_valid  = v[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DIV_LAT-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) zero <= {zero[DIV_LAT-2:0], item.d == '0};
  end

  tcc_div u_div_x (.clk, .en, .num(item.nx), .det(item.d), .quo(qx), .sat(sx));
  tcc_div u_div_y (.clk, .en, .num(item.ny), .det(item.d), .quo(qy), .sat(sy));

  // collinear points give an all-zero result
  assign center_x  = zero[DIV_LAT-1] ? '0 : qx;
  assign center_y  = zero[DIV_LAT-1] ? '0 : qy;
  assign valid_res = !zero[DIV_LAT-1];
  assign saturated = !zero[DIV_LAT-1] && (sx || sy);

endmodule

// ----- rtl/tcc_checker.sv -----
// Port-level checks for the triangle circumcentre block, bound to the top level.
module tcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] center_x,
  input logic signed [47:0] center_y,
  input logic               valid_res,
  input logic               saturated
);

  localparam logic [47:0] MAXV = {1'b0, {47{1'b1}}};
  localparam logic [47:0] MINV = {1'b1, {47{1'b0}}};

  a_reset_empty: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("block not empty straight after reset");

  a_collinear_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (center_x == '0 && center_y == '0 && !saturated))
    else $error("collinear result not all zero");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (center_x == MAXV || center_x == MINV ||
                                  center_y == MAXV || center_y == MINV))
    else $error("saturated flag without a clamped centre");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(center_x) && $stable(center_y)))
    else $error("stalled result dropped or changed");

endmodule

bind triangle_circumcenter tcc_checker u_tcc_checker (.*);
